// ===== design/lrurs_pkg.sv =====
package lrurs_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned FrameBitsDef  = 8;

  typedef enum logic [1:0] {
    OP_TOUCH = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } lrurs_op_e;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DROP  = 2'd3
  } lrurs_status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } lrurs_ctrl_t;

endpackage

// ===== design/lru_recency_stack.sv =====
// Channel   Dir  Handshake             Payload
// s_axis    in   s_axis_tvalid/tready  tuser: op; tdata: frame
// m_axis    out  m_axis_tvalid/tready  tuser: status; tdata: frame_out, dropped_frame, entry_count
//
// One request per cycle unless the output stalls: every cell compares its entry
// with the frame and shifts in the same cycle; the found flag ripples down the row of cells.
// The result is held in the output register from the cycle after acceptance.
// s_axis_tready stays high while the output register is empty or being taken.
// Reset empties the stack; entries need no clearing pass.
module lru_recency_stack import lrurs_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef,
  parameter int unsigned FrameBits  = FrameBitsDef,
  localparam int unsigned CountBits = $clog2(StackDepth + 1),
  localparam int unsigned InBits    = ((FrameBits + 7) / 8) * 8,
  localparam int unsigned OutBits   = ((2 * FrameBits + CountBits + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InBits-1:0]  s_axis_tdata_i,   // frame
  input  logic [1:0]         s_axis_tuser_i,   // op
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OutBits-1:0] m_axis_tdata_o,   // frame_out, dropped_frame, entry_count
  output logic [1:0]         m_axis_tuser_o    // status
);

  localparam int unsigned PadBits = OutBits - 2 * FrameBits - CountBits;

  logic                 accept;
  lrurs_op_e            op;
  logic [FrameBits-1:0] frame;
  lrurs_ctrl_t          ctrl;
  logic                 full, hit;

  logic [CountBits-1:0] occ_q, occ_d;
  logic                 out_valid_q;
  logic [FrameBits-1:0] out_frame_q, out_frame_d;
  logic [FrameBits-1:0] out_drop_q, out_drop_d;
  logic [CountBits-1:0] out_count_q;
  lrurs_status_e        out_status_q, out_status_d;

  logic [FrameBits-1:0] cell_entry [StackDepth];
  logic                 found [StackDepth+1];
  logic [StackDepth-1:0] cell_valid;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = lrurs_op_e'(s_axis_tuser_i);
  assign frame           = s_axis_tdata_i[FrameBits-1:0];
  assign full            = (occ_q == CountBits'(StackDepth));
  assign found[0]        = 1'b0;
  assign hit             = found[StackDepth];

  assign ctrl.push = accept && (op == OP_TOUCH);
  assign ctrl.pop  = accept && (op == OP_POP) && (occ_q != '0);

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    logic [FrameBits-1:0] above, below;
    assign cell_valid[i] = (CountBits'(i) < occ_q);
    if (i == 0) begin : g_top
      assign above = frame;
    end else begin : g_mid
      assign above = cell_entry[i-1];
    end
    if (i == StackDepth - 1) begin : g_bot
      assign below = cell_entry[i];
    end else begin : g_up
      assign below = cell_entry[i+1];
    end
    lrurs_cell #(.FrameBits(FrameBits)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .valid_i (cell_valid[i]),
      .frame_i (frame),
      .above_i (above),
      .below_i (below),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .entry_o (cell_entry[i])
    );
  end

  always_comb begin
    occ_d        = occ_q;
    out_frame_d  = '0;
    out_drop_d   = '0;
    out_status_d = ST_HIT;
    unique case (op)
      OP_TOUCH: begin
        out_frame_d = frame;
        if (hit) begin
          out_status_d = ST_HIT;
        end else if (full) begin
          out_status_d = ST_DROP;
          out_drop_d   = cell_entry[StackDepth-1];
        end else begin
          out_status_d = ST_MISS;
          occ_d        = occ_q + 1'b1;
        end
      end
      OP_POP: begin
        if (occ_q == '0) begin
          out_status_d = ST_EMPTY;
        end else begin
          out_frame_d = cell_entry[0];
          occ_d       = occ_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        occ_d = '0;
      end
      OP_NONE: begin
        occ_d = occ_q;
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q <= occ_d;
      end
      if (s_axis_tready_o) begin
        out_valid_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_frame_q  <= out_frame_d;
      out_drop_q   <= out_drop_d;
      out_status_q <= out_status_d;
      out_count_q  <= occ_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  if (PadBits > 0) begin : g_pad
    assign m_axis_tdata_o = {{PadBits{1'b0}}, out_count_q, out_drop_q, out_frame_q};
  end else begin : g_nopad
    assign m_axis_tdata_o = {out_count_q, out_drop_q, out_frame_q};
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CountBits'(StackDepth))
    else $error("occupancy beyond stack depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_CLEAR) |=> (occ_q == '0 && out_count_q == '0))
    else $error("clear left entries");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_TOUCH && full && !hit) |=> (out_status_q == ST_DROP))
    else $error("miss on full stack not flagged as drop");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |-> (out_count_q == '0))
    else $error("empty pop with entries held");

  a_hit_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_TOUCH && hit) |=> (occ_q == $past(occ_q)))
    else $error("hit changed occupancy");

endmodule

// ===== design/lrurs_cell.sv =====
module lrurs_cell import lrurs_pkg::*; #(
  parameter int unsigned FrameBits = FrameBitsDef
) (
  input  logic                 clk_i,
  input  lrurs_ctrl_t          ctrl_i,
  input  logic                 valid_i,
  input  logic [FrameBits-1:0] frame_i,
  input  logic [FrameBits-1:0] above_i,
  input  logic [FrameBits-1:0] below_i,
  input  logic                 found_i,
  output logic                 found_o,
  output logic [FrameBits-1:0] entry_o
);

  logic [FrameBits-1:0] entry_q, entry_d;
  logic                 match;

  assign match   = valid_i && (entry_q == frame_i);
  assign found_o = found_i || match;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push && !found_i) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== verif/tb_lru_recency_stack.sv =====
`timescale 1ns / 1ps

module tb_lru_recency_stack;
  import lrurs_pkg::*;

  localparam int unsigned Depth  = StackDepthDef;
  localparam int unsigned FrameW = FrameBitsDef;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned InW    = ((FrameW + 7) / 8) * 8;
  localparam int unsigned OutW   = ((2 * FrameW + CountW + 7) / 8) * 8;
  localparam int unsigned DirRows = 25;
  localparam int unsigned PoolMax = 24;

  typedef struct packed {
    logic [FrameW-1:0] frame_out;
    lrurs_status_e     status;
    logic [FrameW-1:0] dropped;
    logic [CountW-1:0] count;
  } lru_result_t;

  typedef struct packed {
    lrurs_op_e         op;
    logic [FrameW-1:0] frame;
    logic              fixed;
    lru_result_t       want;
  } lru_req_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_valid;
  logic              s_axis_tready_o;
  logic [InW-1:0]    s_tdata;
  logic [1:0]        s_tuser;
  logic              m_axis_tvalid_o;
  logic              m_ready;
  logic [OutW-1:0]   m_axis_tdata_o;
  logic [1:0]        m_axis_tuser_o;

  lru_recency_stack DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  logic [FrameW-1:0] recency_q [Depth];
  int                held;
  lru_req_t          inflight_q [$];
  lru_result_t       pending_results [$];
  int                reqs_sent;
  int                reqs_taken;
  int                results_taken;
  int                mismatches;
  bit                no_idle;
  bit                hold_req;
  lru_req_t          acc_req;
  lru_result_t       acc_want;
  lru_result_t       got_res;
  lru_result_t       exp_res;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic lru_result_t predict_recency(lrurs_op_e op, logic [FrameW-1:0] frame);
    lru_result_t r;
    int          hit_at;
    r.frame_out = '0;
    r.status    = ST_HIT;
    r.dropped   = '0;
    hit_at      = -1;
    case (op)
      OP_TOUCH: begin
        r.frame_out = frame;
        for (int i = 0; i < held; i++) begin
          if (hit_at < 0 && recency_q[i] == frame) hit_at = i;
        end
        if (hit_at >= 0) begin
          for (int i = hit_at; i > 0; i--) recency_q[i] = recency_q[i-1];
          r.status = ST_HIT;
        end else if (held >= Depth) begin
          r.dropped = recency_q[Depth-1];
          for (int i = Depth - 1; i > 0; i--) recency_q[i] = recency_q[i-1];
          r.status = ST_DROP;
        end else begin
          for (int i = held; i > 0; i--) recency_q[i] = recency_q[i-1];
          held++;
          r.status = ST_MISS;
        end
        recency_q[0] = frame;
      end
      OP_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.frame_out = recency_q[0];
          for (int i = 0; i + 1 < held; i++) recency_q[i] = recency_q[i+1];
          held--;
        end
      end
      OP_CLEAR: begin
        held = 0;
      end
      default: begin
      end
    endcase
    r.count = CountW'(held);
    return r;
  endfunction

  function automatic lru_result_t result_of(logic [FrameW-1:0] frame_out, lrurs_status_e status,
                                            logic [FrameW-1:0] dropped, int count);
    lru_result_t r;
    r.frame_out = frame_out;
    r.status    = status;
    r.dropped   = dropped;
    r.count     = CountW'(count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) $display("tb: mismatch %s got %0h expected %0h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        acc_req  = inflight_q.pop_front();
        acc_want = predict_recency(acc_req.op, acc_req.frame);
        if (acc_req.fixed) acc_want = acc_req.want;
        pending_results.push_back(acc_want);
        reqs_taken++;
      end
      if (m_axis_tvalid_o && m_ready) begin
        got_res.frame_out = m_axis_tdata_o[FrameW-1:0];
        got_res.dropped   = m_axis_tdata_o[2*FrameW-1:FrameW];
        got_res.count     = m_axis_tdata_o[2*FrameW+CountW-1:2*FrameW];
        got_res.status    = lrurs_status_e'(m_axis_tuser_o);
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, frame_out", got_res.frame_out, 0);
        end else begin
          exp_res = pending_results.pop_front();
          if (got_res.frame_out !== exp_res.frame_out)
            report_mismatch("frame_out", got_res.frame_out, exp_res.frame_out);
          if (got_res.status !== exp_res.status)
            report_mismatch("status", got_res.status, exp_res.status);
          if (got_res.dropped !== exp_res.dropped)
            report_mismatch("dropped_frame", got_res.dropped, exp_res.dropped);
          if (got_res.count !== exp_res.count)
            report_mismatch("entry_count", got_res.count, exp_res.count);
        end
        results_taken++;
      end
    end
  end

  task automatic send_request(input lrurs_op_e op, input logic [FrameW-1:0] frame,
                              input logic fixed, input lru_result_t want);
    int       gap;
    lru_req_t req;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.op    = op;
    req.frame = frame;
    req.fixed = fixed;
    req.want  = want;
    inflight_q.push_back(req);
    reqs_sent++;
    s_valid <= 1'b1;
    s_tdata <= InW'(frame);
    s_tuser <= op;
    do @(negedge clk_i); while (reqs_taken < reqs_sent);
  endtask

  initial begin
    int stall;
    int target;
    m_ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (64) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      target = results_taken + 1;
      do @(negedge clk_i); while (results_taken < target);
    end
  end

  initial begin
    lru_req_t          dir_tab [DirRows];
    logic [FrameW-1:0] fill_frames [16];
    logic [FrameW-1:0] hot_frames [PoolMax];
    int                touch_pct [4];
    int                pop_pct [4];
    int                clear_pct [4];
    int                pool_len [4];
    int                pick;
    lrurs_op_e         op;
    logic [FrameW-1:0] frame;
    lru_result_t       none_res;

    rst_ni        = 1'b0;
    s_valid       = 1'b0;
    s_tdata       = '0;
    s_tuser       = OP_NONE;
    reqs_sent     = 0;
    reqs_taken    = 0;
    results_taken = 0;
    mismatches    = 0;
    held          = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    none_res      = result_of('0, ST_HIT, '0, 0);

    fill_frames = '{8'h80, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                    8'h7F, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF};
    dir_tab[0] = '{OP_POP,   8'h00, 1'b1, result_of(8'h00, ST_EMPTY, 8'h00, 0)};
    dir_tab[1] = '{OP_TOUCH, 8'h00, 1'b1, result_of(8'h00, ST_MISS,  8'h00, 1)};
    dir_tab[2] = '{OP_TOUCH, 8'hFF, 1'b1, result_of(8'hFF, ST_MISS,  8'h00, 2)};
    dir_tab[3] = '{OP_TOUCH, 8'h00, 1'b1, result_of(8'h00, ST_HIT,   8'h00, 2)};
    dir_tab[4] = '{OP_NONE,  8'hAA, 1'b1, result_of(8'h00, ST_HIT,   8'h00, 2)};
    dir_tab[5] = '{OP_POP,   8'h5A, 1'b1, result_of(8'h00, ST_HIT,   8'h00, 1)};
    dir_tab[6] = '{OP_CLEAR, 8'h55, 1'b1, result_of(8'h00, ST_HIT,   8'h00, 0)};
    for (int i = 0; i < 16; i++) dir_tab[7+i] = '{OP_TOUCH, fill_frames[i], 1'b0, none_res};
    dir_tab[23] = '{OP_TOUCH, 8'hAA, 1'b1, result_of(8'hAA, ST_DROP, 8'h80, 16)};
    dir_tab[24] = '{OP_TOUCH, 8'h01, 1'b1, result_of(8'h01, ST_HIT,  8'h00, 16)};

    touch_pct = '{55, 85, 90, 70};
    pop_pct   = '{35, 10,  6, 20};
    clear_pct = '{ 3,  1,  1,  4};
    pool_len  = '{ 6, 24, 20, 12};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++)
      send_request(dir_tab[i].op, dir_tab[i].frame, dir_tab[i].fixed, dir_tab[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      no_idle = (ph == 2);
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < PoolMax; k++) hot_frames[k] = FrameW'($urandom);
      for (int n = 0; n < 163; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < touch_pct[ph]) op = OP_TOUCH;
        else if (pick < touch_pct[ph] + pop_pct[ph]) op = OP_POP;
        else if (pick < touch_pct[ph] + pop_pct[ph] + clear_pct[ph]) op = OP_CLEAR;
        else op = OP_NONE;
        if ($urandom_range(0, 99) < 75) frame = hot_frames[$urandom_range(0, pool_len[ph] - 1)];
        else frame = FrameW'($urandom);
        send_request(op, frame, 1'b0, none_res);
      end
    end

    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== lru_recency_stack.f =====
design/lrurs_pkg.sv
design/lrurs_cell.sv
design/lru_recency_stack.sv
verif/tb_lru_recency_stack.sv
